@@ design/mshq_pkg.sv @@
package mshq_pkg;

  localparam int NCH                = 8;
  localparam int DEF_CHANNELS       = 8;
  localparam int DEF_RUN_COUNT_BITS = 8;

  localparam int RD_W   = 12;
  localparam int OFS_W  = 8;
  localparam int CLN_W  = 13;
  localparam int CHG_W  = 16;
  localparam int HCNT_W = 4;

  // biased corrected value, sum of eight, rounding dividend and 2*n divisor
  localparam int BV_W  = 14;
  localparam int SUM_W = 16;
  localparam int DVD_W = 17;
  localparam int DVS_W = 5;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 136;

  localparam logic signed [RD_W-1:0] DISCONNECTED_RAW = -12'sd2032;
  localparam logic signed [RD_W-1:0] POWER_ON_RAW     = 12'sd1360;
  localparam logic [BV_W-1:0]        MEAN_BIAS        = 14'd4096;

  localparam logic signed [RD_W-1:0] LOW_LIMIT_RST   = -12'sd880;
  localparam logic signed [RD_W-1:0] HIGH_LIMIT_RST  = 12'sd2000;
  localparam logic [7:0]             FAIL_AFTER_RST  = 8'd3;
  localparam logic [7:0]             RECOVER_RST     = 8'd3;
  localparam logic [NCH-1:0]         INIT_MASK_RST   = 8'hFF;

  localparam logic [2:0] REG_LOW_LIMIT   = 3'd0;
  localparam logic [2:0] REG_HIGH_LIMIT  = 3'd1;
  localparam logic [2:0] REG_FAIL_AFTER  = 3'd2;
  localparam logic [2:0] REG_RECOVER     = 3'd3;
  localparam logic [2:0] REG_OFFSETS     = 3'd4;
  localparam logic [2:0] REG_INIT_HEALTH = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_START,
    ST_DIV,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic used;     // good reading on a healthy channel
    logic healthy;  // flag after this round
    logic changed;  // flag flipped this round
  } lane_stat_t;

  typedef struct packed {
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
    logic              none;
    logic [NCH-1:0]    health_mask;
    logic [HCNT_W-1:0] healthy_count;
    logic [CHG_W-1:0]  change_count;
  } merge_res_t;

endpackage

@@ design/mshq_lane.sv @@
module mshq_lane #(
  parameter int   RUN_COUNT_BITS = 8,
  parameter logic HEALTH_RST     = 1'b1
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       upd,
  input  logic signed [mshq_pkg::RD_W-1:0]           reading,
  input  logic signed [mshq_pkg::OFS_W-1:0]          offset,
  input  logic signed [mshq_pkg::RD_W-1:0]           low_limit,
  input  logic signed [mshq_pkg::RD_W-1:0]           high_limit,
  input  logic [7:0]                                 fail_after,
  input  logic [7:0]                                 recover_after,
  input  logic                                       load_health,
  input  logic                                       init_health,
  output mshq_pkg::lane_stat_t                       stat,
  output logic signed [mshq_pkg::CLN_W-1:0]          corr
);
  import mshq_pkg::*;

  localparam int CMP_W = (RUN_COUNT_BITS > 8) ? RUN_COUNT_BITS : 8;
  localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX = {RUN_COUNT_BITS{1'b1}};

  logic [RUN_COUNT_BITS-1:0] good_r, good_nxt;
  logic [RUN_COUNT_BITS-1:0] bad_r, bad_nxt;
  logic                      health_r, health_nxt;
  logic                      used_r, used_nxt;
  logic                      changed_r, changed_nxt;
  logic signed [CLN_W-1:0]   corr_r, corr_nxt;
  logic                      good;

  always_comb begin
    good = !(reading == DISCONNECTED_RAW || reading == POWER_ON_RAW ||
             reading < low_limit || reading > high_limit);
    corr_nxt = {reading[RD_W-1], reading} -
               {{(CLN_W-OFS_W){offset[OFS_W-1]}}, offset};
    health_nxt  = health_r;
    changed_nxt = 1'b0;
    if (good) begin
      bad_nxt  = '0;
      good_nxt = (good_r == RUN_MAX) ? good_r : good_r + 1'b1;
      if (!health_r && (CMP_W'(good_nxt) >= CMP_W'(recover_after))) begin
        health_nxt  = 1'b1;
        changed_nxt = 1'b1;
      end
    end else begin
      good_nxt = '0;
      bad_nxt  = (bad_r == RUN_MAX) ? bad_r : bad_r + 1'b1;
      if (health_r && (CMP_W'(bad_nxt) >= CMP_W'(fail_after))) begin
        health_nxt  = 1'b0;
        changed_nxt = 1'b1;
      end
    end
    used_nxt = good && health_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_r    <= '0;
      bad_r     <= '0;
      health_r  <= HEALTH_RST;
      used_r    <= 1'b0;
      changed_r <= 1'b0;
    end else if (upd) begin
      good_r    <= good_nxt;
      bad_r     <= bad_nxt;
      health_r  <= health_nxt;
      used_r    <= used_nxt;
      changed_r <= changed_nxt;
    end else if (load_health) begin
      health_r <= init_health;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      corr_r <= corr_nxt;
    end
  end

  assign stat.used    = used_r;
  assign stat.healthy = health_r;
  assign stat.changed = changed_r;
  assign corr         = corr_r;

endmodule

@@ design/mshq_merge.sv @@
module mshq_merge (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          start,
  input  mshq_pkg::lane_stat_t [mshq_pkg::NCH-1:0]      stat,
  input  logic signed [mshq_pkg::NCH-1:0][mshq_pkg::CLN_W-1:0] corr,
  output mshq_pkg::merge_res_t                          res
);
  import mshq_pkg::*;

  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [HCNT_W-1:0] n_r, n_nxt;
  logic [NCH-1:0]    mask_r, mask_nxt;
  logic [HCNT_W-1:0] hcnt_r, hcnt_nxt;
  logic [CHG_W-1:0]  chg_r, chg_nxt;
  logic [HCNT_W-1:0] flips;
  logic [CHG_W:0]    chg_sum;
  logic [BV_W-1:0]   biased;

  always_comb begin
    sum_nxt  = '0;
    n_nxt    = '0;
    hcnt_nxt = '0;
    flips    = '0;
    biased   = '0;
    for (int i = 0; i < NCH; i++) begin
      biased      = {corr[i][CLN_W-1], corr[i]} + MEAN_BIAS;
      mask_nxt[i] = stat[i].healthy;
      hcnt_nxt    = hcnt_nxt + HCNT_W'(stat[i].healthy);
      flips       = flips + HCNT_W'(stat[i].changed);
      if (stat[i].used) begin
        sum_nxt = sum_nxt + SUM_W'(biased);
        n_nxt   = n_nxt + 1'b1;
      end
    end
    chg_sum = {1'b0, chg_r} + (CHG_W+1)'(flips);
    chg_nxt = chg_sum[CHG_W] ? {CHG_W{1'b1}} : chg_sum[CHG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chg_r <= '0;
    end else if (start) begin
      chg_r <= chg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum_r  <= sum_nxt;
      n_r    <= n_nxt;
      mask_r <= mask_nxt;
      hcnt_r <= hcnt_nxt;
    end
  end

  // rounded mean: (2*S + n) / (2*n)
  assign res.dividend      = {sum_r, 1'b0} + DVD_W'(n_r);
  assign res.divisor       = {n_r, 1'b0};
  assign res.none          = (n_r == '0);
  assign res.health_mask   = mask_r;
  assign res.healthy_count = hcnt_r;
  assign res.change_count  = chg_r;

endmodule

@@ design/mshq_div.sv @@
module mshq_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mshq_pkg::DVD_W-1:0]   dividend,
  input  logic [mshq_pkg::DVS_W-1:0]   divisor,
  output logic                         done,
  output logic [mshq_pkg::DVD_W-1:0]   quotient
);
  import mshq_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W:0]   rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    trial    = {rem_r[DVS_W-1:0], quo_r[DVD_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ design/multi_sensor_health_qualifier_unit.sv @@
// Multi-sensor health qualifier.
// in_*  : one transaction carries a round of eight 12-bit signed readings in
//         sixteenths of a degree. in_tready is high only while the unit is
//         idle, so one round is worked on at a time.
// out_* : one transaction per round: eight cleaned 13-bit values (own
//         corrected reading, or the rounded mean of the counted channels),
//         health mask, healthy count and the saturating change total.
//         out_tuser is 0 when no channel counted and the old values repeat.
// cfg_* : register writes, always ready; write only while the unit is idle.
//         Writing the initial health mask also reloads the health flags.
// Flow: eight lanes qualify the readings and update their run counters
//   in the accept cycle, the merge stage then sums them, then a restoring
//   divider produces one quotient bit per cycle; the divider is skipped when
//   no channel counts. The next round is taken only after the result is
//   loaded, so one round is worked on at a time.
// Stall: the result sits in an output register; a round that finishes while
//   it is still unread waits before loading, and the input stays closed.
// Reset: settings, state and output valid to reset values, flags from the
//   reset mask; run counters, held values and change total cleared.
module multi_sensor_health_qualifier_unit #(
  parameter int CHANNELS       = mshq_pkg::DEF_CHANNELS,
  parameter int RUN_COUNT_BITS = mshq_pkg::DEF_RUN_COUNT_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // reading_0 .. reading_7, 12 bits each
  input  logic [mshq_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // cleaned_0 .. cleaned_7 (13 bits each), health_mask, healthy_count,
  // change_count, zero pad
  output logic [mshq_pkg::OUT_DATA_W-1:0]     out_tdata,
  // updated
  output logic                                out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [2:0]                          cfg_index,
  input  logic [63:0]                         cfg_data
);
  import mshq_pkg::*;

  state_t state_r, state_nxt;

  logic signed [RD_W-1:0]  low_r, high_r;
  logic [7:0]              fail_r, rec_r;
  logic [NCH*OFS_W-1:0]    offs_r;
  logic                    cfg_wr, load_health, accept;

  lane_stat_t [NCH-1:0]              stat;
  logic signed [NCH-1:0][CLN_W-1:0]  corr;
  merge_res_t                        mres;

  logic                    merge_start, div_start, div_done, load_out;
  logic [DVD_W-1:0]        quotient;
  logic signed [CLN_W-1:0] mean;

  logic signed [NCH-1:0][CLN_W-1:0] held_r, held_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;
  logic                    out_user_r;

  assign cfg_ready   = 1'b1;
  assign cfg_wr      = cfg_valid && cfg_ready;
  assign load_health = cfg_wr && (cfg_index == REG_INIT_HEALTH);
  assign accept      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r       <= LOW_LIMIT_RST;
      high_r      <= HIGH_LIMIT_RST;
      fail_r      <= FAIL_AFTER_RST;
      rec_r       <= RECOVER_RST;
      offs_r      <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_LOW_LIMIT:   low_r       <= cfg_data[RD_W-1:0];
        REG_HIGH_LIMIT:  high_r      <= cfg_data[RD_W-1:0];
        REG_FAIL_AFTER:  fail_r      <= cfg_data[7:0];
        REG_RECOVER:     rec_r       <= cfg_data[7:0];
        REG_OFFSETS:     offs_r      <= cfg_data[NCH*OFS_W-1:0];
        default:         ;
      endcase
    end
  end

  for (genvar i = 0; i < NCH; i++) begin : g_lane
    if (i < CHANNELS) begin : g_used
      mshq_lane #(
        .RUN_COUNT_BITS (RUN_COUNT_BITS),
        .HEALTH_RST     (INIT_MASK_RST[i])
      ) u_lane (
        .clk           (clk),
        .rst_n         (rst_n),
        .upd           (accept),
        .reading       (in_tdata[RD_W*i +: RD_W]),
        .offset        (offs_r[OFS_W*i +: OFS_W]),
        .low_limit     (low_r),
        .high_limit    (high_r),
        .fail_after    (fail_r),
        .recover_after (rec_r),
        .load_health   (load_health),
        .init_health   (cfg_data[i]),
        .stat          (stat[i]),
        .corr          (corr[i])
      );
    end else begin : g_unused
      assign stat[i] = '0;
      assign corr[i] = '0;
    end
  end

  mshq_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .start (merge_start),
    .stat  (stat),
    .corr  (corr),
    .res   (mres)
  );

  mshq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mres.dividend),
    .divisor  (mres.divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // quotient stays below 2^13, so the bias comes off modulo 2^13
  assign mean = quotient[CLN_W-1:0] - MEAN_BIAS[CLN_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    merge_start = 1'b0;
    div_start   = 1'b0;
    load_out    = 1'b0;
    in_tready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        merge_start = 1'b1;
        state_nxt   = ST_START;
      end
      ST_START: begin
        if (mres.none) begin
          state_nxt = ST_LOAD;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    held_nxt = held_r;
    if (!mres.none) begin
      for (int i = 0; i < NCH; i++) begin
        if (i < CHANNELS) begin
          held_nxt[i] = stat[i].used ? corr[i] : mean;
        end
      end
    end
    out_data_nxt = '0;
    for (int i = 0; i < NCH; i++) begin
      out_data_nxt[CLN_W*i +: CLN_W] = held_nxt[i];
    end
    out_data_nxt[NCH*CLN_W +: NCH]                  = mres.health_mask;
    out_data_nxt[NCH*CLN_W+NCH +: HCNT_W]           = mres.healthy_count;
    out_data_nxt[NCH*CLN_W+NCH+HCNT_W +: CHG_W]     = mres.change_count;

    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      held_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (load_out) begin
        held_r <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= out_data_nxt;
      out_user_r <= !mres.none;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_count_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($countones(out_tdata[NCH*CLN_W +: NCH]) ==
                    int'(out_tdata[NCH*CLN_W+NCH +: HCNT_W])))
    else $error("healthy_count disagrees with health_mask");

  a_accept_starts_merge: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_MERGE) && !in_tready)
    else $error("accepted round did not go to merge");

  a_done_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_held_when_none: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && mres.none) |=> ($past(held_r) == held_r))
    else $error("held values changed although no channel counted");
`endif

endmodule

@@ verif/multi_sensor_health_qualifier_unit_tb.sv @@
`timescale 1ns / 100ps

module multi_sensor_health_qualifier_unit_tb;
  import mshq_pkg::*;

  localparam int RUN_SAT     = 255;
  localparam int SUM_BIAS    = 4096;
  localparam int MAX_REPORTS = 60;
  localparam int RAW_DISC    = DISCONNECTED_RAW;
  localparam int RAW_POWER   = POWER_ON_RAW;

  localparam int HMASK_LSB = NCH * CLN_W;
  localparam int HCNT_LSB  = HMASK_LSB + NCH;
  localparam int CHG_LSB   = HCNT_LSB + HCNT_W;
  localparam int PAD_LSB   = CHG_LSB + CHG_W;

  // indexes the block has no register for
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef int round_vals_t [NCH];

  typedef struct packed {
    logic [NCH-1:0][CLN_W-1:0] cleaned;
    logic                      updated;
    logic [NCH-1:0]            health_mask;
    logic [HCNT_W-1:0]         healthy_count;
    logic [CHG_W-1:0]          change_count;
  } round_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [2:0]            cfg_index  = '0;
  logic [63:0]           cfg_data   = '0;

  multi_sensor_health_qualifier_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // qualifier state and register copies
  logic signed [RD_W-1:0] lim_low, lim_high;
  logic [7:0]             fail_thr, recover_thr;
  logic [63:0]            offset_bytes;
  logic [NCH-1:0]         chan_healthy;
  logic [7:0]             bad_run [NCH];
  logic [7:0]             good_run [NCH];
  logic [CLN_W-1:0]       held_cleaned [NCH];
  logic [CHG_W-1:0]       change_total;

  round_result_t          expected_rounds [$];
  round_result_t          oldest;
  logic [IN_DATA_W-1:0]   pending_rounds [$];

  int  rounds_pushed = 0;
  int  rounds_checked = 0;
  int  mismatch_count = 0;
  int  held_rounds = 0;
  int  settings_count = 0;
  int  last_changes = 0;
  int  send_gap = 0;
  int  recv_stall = 0;
  logic idling_on = 1'b1;

  // stimulus-side view of the limits, kept apart from the predictor
  int  stim_low = -880;
  int  stim_high = 2000;
  int  fault_left [NCH];

  function automatic round_result_t qualify_round(logic [IN_DATA_W-1:0] rd);
    round_result_t  res;
    int             v, n, biased_sum, mean;
    int             corr [NCH];
    logic           good;
    logic [NCH-1:0] counted;
    res = '0;
    n = 0;
    biased_sum = 0;
    counted = '0;
    for (int i = 0; i < NCH; i++) begin
      v = int'($signed(rd[RD_W*i +: RD_W]));
      good = !(v == RAW_DISC || v == RAW_POWER || v < int'(lim_low) || v > int'(lim_high));
      corr[i] = v - int'($signed(offset_bytes[8*i +: 8]));
      if (good) begin
        bad_run[i] = '0;
        if (good_run[i] != RUN_SAT) good_run[i]++;
        if (!chan_healthy[i] && good_run[i] >= recover_thr) begin
          chan_healthy[i] = 1'b1;
          if (change_total != '1) change_total++;
        end
        if (chan_healthy[i]) begin
          counted[i] = 1'b1;
          biased_sum += corr[i] + SUM_BIAS;
          n++;
        end
      end else begin
        good_run[i] = '0;
        if (bad_run[i] != RUN_SAT) bad_run[i]++;
        if (chan_healthy[i] && bad_run[i] >= fail_thr) begin
          chan_healthy[i] = 1'b0;
          if (change_total != '1) change_total++;
        end
      end
    end
    if (n != 0) begin
      // round to nearest, ties up; bias keeps the division on positives
      mean = (2 * biased_sum + n) / (2 * n) - SUM_BIAS;
      for (int i = 0; i < NCH; i++)
        held_cleaned[i] = counted[i] ? CLN_W'(corr[i]) : CLN_W'(mean);
    end
    for (int i = 0; i < NCH; i++)
      res.cleaned[i] = held_cleaned[i];
    res.updated       = (n != 0);
    res.health_mask   = chan_healthy;
    res.healthy_count = HCNT_W'($countones(chan_healthy));
    res.change_count  = change_total;
    return res;
  endfunction

  task automatic report_mismatch(string field, int exp_val, int got_val);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $error("%s: expected %0d, got %0d", field, exp_val, got_val);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lim_low      <= LOW_LIMIT_RST;
      lim_high     <= HIGH_LIMIT_RST;
      fail_thr     <= FAIL_AFTER_RST;
      recover_thr  <= RECOVER_RST;
      offset_bytes <= '0;
      chan_healthy <= INIT_MASK_RST;
      change_total <= '0;
      for (int i = 0; i < NCH; i++) begin
        bad_run[i]      <= '0;
        good_run[i]     <= '0;
        held_cleaned[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOW_LIMIT:   lim_low = cfg_data[RD_W-1:0];
          REG_HIGH_LIMIT:  lim_high = cfg_data[RD_W-1:0];
          REG_FAIL_AFTER:  fail_thr = cfg_data[7:0];
          REG_RECOVER:     recover_thr = cfg_data[7:0];
          REG_OFFSETS:     offset_bytes = cfg_data;
          REG_INIT_HEALTH: chan_healthy = cfg_data[NCH-1:0];
          default: ;
        endcase
      end
      // result side first, so a round never meets its own transaction
      if (out_tvalid && out_tready) begin
        if (expected_rounds.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $error("result transaction with no round outstanding");
        end else begin
          oldest = expected_rounds.pop_front();
          rounds_checked++;
          for (int i = 0; i < NCH; i++)
            if (out_tdata[CLN_W*i +: CLN_W] !== oldest.cleaned[i])
              report_mismatch($sformatf("cleaned_%0d", i), int'($signed(oldest.cleaned[i])),
                              int'($signed(out_tdata[CLN_W*i +: CLN_W])));
          if (out_tuser !== oldest.updated)
            report_mismatch("updated", oldest.updated, out_tuser);
          if (out_tdata[HMASK_LSB +: NCH] !== oldest.health_mask)
            report_mismatch("health_mask", oldest.health_mask, out_tdata[HMASK_LSB +: NCH]);
          if (out_tdata[HCNT_LSB +: HCNT_W] !== oldest.healthy_count)
            report_mismatch("healthy_count", oldest.healthy_count,
                            out_tdata[HCNT_LSB +: HCNT_W]);
          if (out_tdata[CHG_LSB +: CHG_W] !== oldest.change_count)
            report_mismatch("change_count", oldest.change_count, out_tdata[CHG_LSB +: CHG_W]);
          if (out_tdata[OUT_DATA_W-1:PAD_LSB] !== '0)
            report_mismatch("pad", 0, out_tdata[OUT_DATA_W-1:PAD_LSB]);
          if (!oldest.updated) held_rounds++;
          last_changes = oldest.change_count;
        end
      end
      if (in_tvalid && in_tready)
        expected_rounds.push_back(qualify_round(in_tdata));
    end
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap != 0) begin
        in_tvalid <= 1'b0;
        send_gap  <= send_gap - 1;
      end else if (pending_rounds.size() != 0) begin
        in_tdata  <= pending_rounds.pop_front();
        in_tvalid <= 1'b1;
        if (idling_on && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 5);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall <= 0;
    end else if (recv_stall != 0) begin
      out_tready <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      recv_stall <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [RD_W-1:0] pick_good();
    int v;
    if (stim_low > stim_high) return RD_W'($urandom);
    do begin
      case ($urandom_range(0, 15))
        0:       v = stim_low;
        1:       v = stim_high;
        default: v = stim_low + int'($urandom_range(0, stim_high - stim_low));
      endcase
    end while (v == RAW_DISC || v == RAW_POWER);
    return RD_W'(v);
  endfunction

  function automatic logic [RD_W-1:0] pick_bad();
    int v;
    case ($urandom_range(0, 5))
      0: v = RAW_DISC;
      1: v = RAW_POWER;
      2: v = (stim_low > -2048) ? stim_low - 1 : RAW_DISC;
      3: v = (stim_high < 2047) ? stim_high + 1 : RAW_POWER;
      4: v = (stim_high < 2047) ?
             stim_high + 1 + int'($urandom_range(0, 2046 - stim_high)) : RAW_DISC;
      default: v = (stim_low > -2048) ?
                   stim_low - 1 - int'($urandom_range(0, stim_low + 2047)) : RAW_POWER;
    endcase
    return RD_W'(v);
  endfunction

  // channels fall into bad stretches and come back, so health flags really move
  function automatic logic [IN_DATA_W-1:0] make_round(int noise_pct, int fault_pct,
                                                       int run_max);
    logic [IN_DATA_W-1:0] rd;
    logic [RD_W-1:0]      v;
    rd = '0;
    for (int i = 0; i < NCH; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        v = RD_W'($urandom);
      end else if (fault_left[i] > 0) begin
        v = pick_bad();
        fault_left[i]--;
      end else if ($urandom_range(0, 99) < fault_pct) begin
        v = pick_bad();
        fault_left[i] = $urandom_range(0, run_max - 1);
      end else begin
        v = pick_good();
      end
      rd[RD_W*i +: RD_W] = v;
    end
    return rd;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_round(round_vals_t vals);
    logic [IN_DATA_W-1:0] rd;
    for (int i = 0; i < NCH; i++)
      rd[RD_W*i +: RD_W] = RD_W'(vals[i]);
    return rd;
  endfunction

  task automatic queue_round(logic [IN_DATA_W-1:0] rd);
    pending_rounds.push_back(rd);
    rounds_pushed++;
  endtask

  task automatic push_rounds(int count, int noise_pct, int fault_pct, int run_max);
    for (int k = 0; k < count; k++)
      queue_round(make_round(noise_pct, fault_pct, run_max));
  endtask

  // returns at a rising edge once every queued round has produced its result
  task automatic wait_drained();
    do @(negedge clk); while (rounds_checked != rounds_pushed);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(int low, int high, int fail_n, int recover_n,
                                logic [63:0] offs, logic [7:0] mask, bit poke_spare);
    wait_drained();
    write_reg(REG_LOW_LIMIT, 64'(low));
    write_reg(REG_HIGH_LIMIT, 64'(high));
    write_reg(REG_FAIL_AFTER, 64'(fail_n));
    write_reg(REG_RECOVER, 64'(recover_n));
    write_reg(REG_OFFSETS, offs);
    write_reg(REG_INIT_HEALTH, 64'(mask));
    if (poke_spare) begin
      write_reg(REG_SPARE_A, {$urandom, $urandom});
      write_reg(REG_SPARE_B, {$urandom, $urandom});
    end
    cfg_valid <= 1'b0;
    stim_low  = low;
    stim_high = high;
    settings_count++;
  endtask

  initial begin
    #5ms;
    $display("multi_sensor_health_qualifier_unit regression: fail");
    $finish;
  end

  initial begin
    int low_l, high_l, fail_l, recover_l;
    for (int i = 0; i < NCH; i++) fault_left[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: specials, limit edges, rounding ties, all-bad rounds
    queue_round(pack_round('{0, 0, 0, 0, 0, 0, 0, 0}));
    queue_round(pack_round('{0, 1, RAW_DISC, RAW_DISC, RAW_POWER, RAW_POWER, 2047, -2048}));
    queue_round(pack_round('{-1, 0, RAW_DISC, RAW_POWER, 2001, -881, 2047, -2048}));
    queue_round(pack_round('{-880, 2000, -881, 2001, RAW_DISC, RAW_POWER, 1359, -2031}));
    queue_round(pack_round('{RAW_DISC, RAW_DISC, RAW_DISC, RAW_DISC,
                             RAW_DISC, RAW_DISC, RAW_DISC, RAW_DISC}));
    queue_round(pack_round('{RAW_POWER, RAW_POWER, RAW_POWER, RAW_POWER,
                             RAW_POWER, RAW_POWER, RAW_POWER, RAW_POWER}));
    queue_round(pack_round('{2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047}));
    queue_round(pack_round('{-2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048}));
    queue_round(pack_round('{100, -200, 300, -400, 500, -600, 700, -800}));
    queue_round(pack_round('{100, -200, 300, -400, 500, -600, 700, -800}));
    queue_round(pack_round('{1999, -879, 5, -5, 0, 1, 2, 3}));
    queue_round(pack_round('{2000, 2000, 2000, 2000, 2000, 2000, 2000, 2000}));
    queue_round(pack_round('{-880, -880, -880, -880, -880, -880, -880, -880}));
    queue_round(pack_round('{2000, -880, 1, -1, 7, -7, 1000, -500}));

    // moderate settings; the sender holds off mid-way until all results are in
    apply_settings(-600, 1500, 2, 4, {$urandom, $urandom}, 8'hFF, 1'b1);
    push_rounds(120, 5, 10, 5);
    wait_drained();
    push_rounds(120, 5, 10, 5);

    // longest thresholds: the low half recovers and channel 7 fails only after
    // 255 rounds, then its bad run saturates
    apply_settings(-800, 1800, 255, 255, {$urandom, $urandom}, 8'hF0, 1'b0);
    fault_left[7] = 1000000;
    push_rounds(270, 0, 0, 1);
    fault_left[7] = 0;

    // crossed limits with zero thresholds: everything bad, values held
    apply_settings(500, -500, 0, 0, {$urandom, $urandom}, 8'h3C, 1'b1);
    push_rounds(12, 100, 0, 1);

    // widest limits, extreme offsets
    apply_settings(-2048, 2047, 0, 0, 64'h807F_807F_7F80_7F80, 8'hA5, 1'b0);
    push_rounds(150, 20, 10, 3);

    for (int ph = 0; ph < 4; ph++) begin
      low_l     = -int'($urandom_range(0, 1200));
      high_l    = int'($urandom_range(200, 2047));
      fail_l    = $urandom_range(1, 6);
      recover_l = $urandom_range(1, 6);
      apply_settings(low_l, high_l, fail_l, recover_l, {$urandom, $urandom},
                     8'($urandom_range(0, 255)), ph[0]);
      if (ph == 3) idling_on <= 1'b0;
      push_rounds(100, 5, 10, fail_l + 2);
    end

    wait_drained();
    repeat (40) @(posedge clk);
    $display("%0d rounds checked under %0d register settings (%0d held, %0d health changes)",
             rounds_checked, settings_count + 1, held_rounds, last_changes);
    if (mismatch_count == 0 && expected_rounds.size() == 0)
      $display("multi_sensor_health_qualifier_unit regression: pass");
    else
      $display("multi_sensor_health_qualifier_unit regression: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
design/mshq_pkg.sv
design/mshq_lane.sv
design/mshq_merge.sv
design/mshq_div.sv
design/multi_sensor_health_qualifier_unit.sv
verif/multi_sensor_health_qualifier_unit_tb.sv
